### sv/escaped_channel_demux_fifos_assert.svh
// Assertion macros for the channel demultiplexer checker.
`ifndef ESCAPED_CHANNEL_DEMUX_FIFOS_ASSERT_SVH
`define ESCAPED_CHANNEL_DEMUX_FIFOS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ECDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecdf check failed");

// Next-cycle implication, disabled during reset.
`define ECDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecdf check failed");

`endif

### sv/ecdf_pkg.sv
// Shared types, constants and codes of the channel demultiplexer.
package ecdf_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int RAM_DEPTH  = NUM_CH << PTR_W;

  // Link control bytes
  localparam logic [7:0] SEL_MASK = 8'hFC;
  localparam logic [7:0] SEL_BASE = 8'hC0;
  localparam logic [7:0] ESC_BYTE = 8'hCE;

  localparam logic OP_LINK = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_CONTROL = 3'd1;
  localparam logic [2:0] ST_NOCHAN  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_POPPED  = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  typedef struct packed {
    logic            opcode;
    logic [7:0]      link_byte;
    logic [CH_W-1:0] pop_channel;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [7:0]      data_out;
    logic [CH_W-1:0] channel_out;
    logic            overflow_seen;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // item transfer this cycle
    logic load_pop;  // capture RAM read data into the result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read; // current item pops a stored byte
  } dp_status_t;

endpackage

### sv/escaped_channel_demux_fifos.sv
// Top level of the byte-stuffed four-channel demultiplexer with receive FIFOs.
// One item is handled at a time. A link byte or a pop of an empty FIFO is
// decoded in the transfer cycle and its result is offered on the next cycle;
// a pop that returns a stored byte first waits for the registered read of
// the storage RAM (4 x FIFO_DEPTH bytes, one write and one read port). A new
// item is taken only once the previous result has been transferred, so any
// out_stall holds off the next item. No clearing pass is needed after reset.
module escaped_channel_demux_fifos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ecdf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ecdf_pkg::out_item_t out_data
);
  import ecdf_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;

  ecdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ecdf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

### sv/ecdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### sv/ecdf_ctrl.sv
// Controller state machine: item handshake, RAM read wait and result hold.
module ecdf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ecdf_pkg::dp_status_t  stat,
  output ecdf_pkg::ctl_cmd_t    cmd
);
  import ecdf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign cmd.accept   = in_valid && (state_r == S_IDLE);
  assign cmd.load_pop = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/ecdf_dp.sv
// Datapath: link byte decode, per-channel FIFO pointers, storage RAM, result register.
module ecdf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ecdf_pkg::ctl_cmd_t   cmd,
  input  ecdf_pkg::in_item_t   in_data,
  output ecdf_pkg::dp_status_t stat,
  output ecdf_pkg::out_item_t  out_data
);
  import ecdf_pkg::*;

  logic [CH_W-1:0]  sel_ch_r, sel_ch_nxt;
  logic             sel_vld_r, sel_vld_nxt;
  logic             esc_r, esc_nxt;
  logic [PTR_W-1:0] rd_ptr_r [NUM_CH];
  logic [PTR_W-1:0] wr_ptr_r [NUM_CH];
  logic [CNT_W-1:0] cnt_r    [NUM_CH];
  logic [NUM_CH-1:0] ovf_r, ovf_nxt;
  out_item_t        out_r;
  out_item_t        res;

  logic             is_sel, is_esc;
  logic [CH_W-1:0]  ch_idx;
  logic [CNT_W-1:0] ch_cnt;
  logic [PTR_W-1:0] ch_rd_ptr, ch_wr_ptr;
  logic             do_pop, do_push;
  logic [7:0]       rd_byte;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  assign is_sel = !esc_r && ((in_data.link_byte & SEL_MASK) == SEL_BASE);
  assign is_esc = !esc_r && (in_data.link_byte == ESC_BYTE);

  // One channel is looked at per item
  always_comb begin
    priority if (in_data.opcode == OP_POP) begin
      ch_idx = in_data.pop_channel;
    end else if (is_sel) begin
      ch_idx = in_data.link_byte[CH_W-1:0];
    end else begin
      ch_idx = sel_ch_r;
    end
  end

  assign ch_cnt    = cnt_r[ch_idx];
  assign ch_rd_ptr = rd_ptr_r[ch_idx];
  assign ch_wr_ptr = wr_ptr_r[ch_idx];

  always_comb begin
    sel_ch_nxt  = sel_ch_r;
    sel_vld_nxt = sel_vld_r;
    esc_nxt     = esc_r;
    ovf_nxt     = ovf_r;
    do_pop      = 1'b0;
    do_push     = 1'b0;
    res.status        = ST_CONTROL;
    res.data_out      = '0;
    res.channel_out   = '0;
    res.overflow_seen = 1'b0;
    priority if (in_data.opcode == OP_POP) begin
      res.channel_out   = ch_idx;
      res.overflow_seen = ovf_r[ch_idx];
      if (ch_cnt == '0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_POPPED;
        do_pop     = 1'b1;
      end
    end else if (is_sel) begin
      sel_ch_nxt        = ch_idx;
      sel_vld_nxt       = 1'b1;
      res.channel_out   = ch_idx;
      res.overflow_seen = ovf_r[ch_idx];
    end else if (is_esc) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      if (!sel_vld_r) begin
        res.status = ST_NOCHAN;
      end else if (ch_cnt == CNT_W'(FIFO_DEPTH)) begin
        ovf_nxt[ch_idx]   = 1'b1;
        res.status        = ST_FULL;
        res.channel_out   = ch_idx;
        res.overflow_seen = 1'b1;
      end else begin
        do_push           = 1'b1;
        res.status        = ST_STORED;
        res.channel_out   = ch_idx;
        res.overflow_seen = ovf_r[ch_idx];
      end
    end
  end

  assign stat.need_read = do_pop;

  ecdf_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.accept && do_push),
    .wr_addr ({ch_idx, ch_wr_ptr}),
    .wr_data (in_data.link_byte),
    .rd_en   (cmd.accept && do_pop),
    .rd_addr ({ch_idx, ch_rd_ptr}),
    .rd_data (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_ch_r  <= '0;
      sel_vld_r <= 1'b0;
      esc_r     <= 1'b0;
      ovf_r     <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
    end else if (cmd.accept) begin
      sel_ch_r  <= sel_ch_nxt;
      sel_vld_r <= sel_vld_nxt;
      esc_r     <= esc_nxt;
      ovf_r     <= ovf_nxt;
      if (do_pop) begin
        rd_ptr_r[ch_idx] <= ptr_inc(ch_rd_ptr);
        cnt_r[ch_idx]    <= ch_cnt - 1'b1;
      end
      if (do_push) begin
        wr_ptr_r[ch_idx] <= ptr_inc(ch_wr_ptr);
        cnt_r[ch_idx]    <= ch_cnt + 1'b1;
      end
    end
  end

  // Result register; the popped byte is loaded from the registered RAM read data in the read-wait state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_r <= res;
    end else if (cmd.load_pop) begin
      out_r.data_out <= rd_byte;
    end
  end

  assign out_data = out_r;

endmodule

### sv/ecdf_checker.sv
// Port-level checks on the demultiplexer's result channel, bound to the top level.
`include "escaped_channel_demux_fifos_assert.svh"

module ecdf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input ecdf_pkg::out_item_t out_data
);
  import ecdf_pkg::*;

  logic no_data_status;
  logic nochan_res;
  logic full_res;

  assign no_data_status = (out_data.status == ST_STORED) || (out_data.status == ST_CONTROL) ||
                          (out_data.status == ST_NOCHAN) || (out_data.status == ST_FULL) ||
                          (out_data.status == ST_EMPTY);
  assign nochan_res = out_valid && (out_data.status == ST_NOCHAN);
  assign full_res   = out_valid && (out_data.status == ST_FULL);

  `ECDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `ECDF_ASSERT_NOW(a_status_range, clk, rst_n, out_valid, out_data.status <= ST_EMPTY)
  `ECDF_ASSERT_NOW(a_data_zero, clk, rst_n, out_valid && no_data_status, out_data.data_out == 8'd0)
  `ECDF_ASSERT_NOW(a_nochan_quiet, clk, rst_n, nochan_res, out_data.channel_out == '0 && !out_data.overflow_seen)
  `ECDF_ASSERT_NOW(a_full_flag, clk, rst_n, full_res, out_data.overflow_seen)

endmodule

bind escaped_channel_demux_fifos ecdf_checker u_ecdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
